[src/mpn_pkg.sv]
package mpn_pkg;

	// opcodes carried in s_tuser
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_RENDER  = 2'd2;

	// register select, taken from paddr[2]
	localparam logic REG_COLOR_MODE  = 1'b0;
	localparam logic REG_MASK_ENABLE = 1'b1;
	localparam int   ADDR_W          = 3;

	localparam int NUM_LANES   = 3;
	localparam int MASK_W      = 8;
	localparam int LEVEL_W     = 8;
	localparam int QUOT_W      = 9;   // 8 quotient bits plus saturation bit
	localparam int IDX_W       = 4;
	localparam int SMALL_PEAK  = 4;
	localparam int DIV_DEFAULT = 255;

	localparam logic [MASK_W-1:0]  MASK_FULL = 8'hff;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hff;
	localparam logic [IDX_W-1:0]   IDX_TOP   = 4'(QUOT_W - 1);

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} lane_ctrl_t;

	// red in the lowest byte
	typedef struct packed {
		logic [LEVEL_W-1:0] alpha;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
	} pixel_t;

endpackage

[src/masked_peak_normalize_rgb8.sv]
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tuser opcode, tdata samples and masks
// m_*       out  m_tvalid / m_tready       tdata RGBA pixel
// APB       in   psel, penable, pready=1   color_mode @0x0, mask_enable @0x4
//
// Start and measure requests leave s_tready high. A render request runs
// through one load, nine divider steps (one quotient bit per step in
// each of the three lanes) and one merge into the output register.
// If the output register is full and not being read the pixel waits in the
// merge state; the next request is taken the cycle after the pixel is stored.
// Asynchronous active-low reset clears peak, registers and control.
module masked_peak_normalize_rgb8 #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// tdata, from bit 0: red_sample, red_mask, green_sample, green_mask,
	// blue_sample, blue_mask, zero pad to whole bytes
	input  logic [((3*SAMPLE_BITS+24+7)/8)*8-1:0] s_tdata,
	// tuser: opcode
	input  logic [1:0]                   s_tuser,
	// master stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tdata, from bit 0: red_out, green_out, blue_out, alpha_out
	output logic [31:0]                  m_tdata,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mpn_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int FIELD_W = SAMPLE_BITS + mpn_pkg::MASK_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;

	logic [1:0]                  state_q;
	logic [mpn_pkg::IDX_W-1:0]   idx_q;
	logic                        color_mode_q;
	logic                        mask_enable_q;
	logic [SAMPLE_BITS-1:0]      peak_q;
	logic [mpn_pkg::MASK_W-1:0]  mask_q [mpn_pkg::NUM_LANES];
	mpn_pkg::pixel_t             out_q;
	logic                        out_valid_q;

	logic                        in_acc;
	logic                        cfg_wr;
	logic                        out_load;
	logic [SAMPLE_BITS-1:0]      divisor;
	logic [SAMPLE_BITS-1:0]      sample [mpn_pkg::NUM_LANES];
	logic [mpn_pkg::MASK_W-1:0]  mask_eff [mpn_pkg::NUM_LANES];
	logic [mpn_pkg::LEVEL_W-1:0] level [mpn_pkg::NUM_LANES];
	mpn_pkg::lane_ctrl_t         ctrl;
	mpn_pkg::pixel_t             pixel;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == mpn_pkg::REG_MASK_ENABLE) ? {31'b0, mask_enable_q}
	                                                       : {31'b0, color_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q  <= 1'b0;
			mask_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				mpn_pkg::REG_COLOR_MODE:  color_mode_q  <= pwdata[0];
				mpn_pkg::REG_MASK_ENABLE: mask_enable_q <= pwdata[0];
			endcase
		end
	end

	// ---- request fields; masking off reads every mask as full ----
	for (genvar j = 0; j < mpn_pkg::NUM_LANES; j++) begin : g_field
		assign sample[j]   = s_tdata[j*FIELD_W +: SAMPLE_BITS];
		assign mask_eff[j] = mask_enable_q ? s_tdata[j*FIELD_W+SAMPLE_BITS +: mpn_pkg::MASK_W]
		                                   : mpn_pkg::MASK_FULL;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// small peaks fall back to 255 as divisor
	assign divisor = (peak_q < SAMPLE_BITS'(mpn_pkg::SMALL_PEAK))
	                 ? SAMPLE_BITS'(mpn_pkg::DIV_DEFAULT) : peak_q;

	// ---- running peak ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (in_acc) begin
			if (s_tuser == mpn_pkg::OP_START) begin
				peak_q <= '0;
			end else if (s_tuser == mpn_pkg::OP_MEASURE && mask_eff[0] != '0
			             && sample[0] > peak_q) begin
				peak_q <= sample[0];
			end
		end
	end

	// ---- sequencer ----
	assign out_load = (state_q == ST_MERGE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == mpn_pkg::OP_RENDER) begin
						state_q <= ST_DIV;
						idx_q   <= mpn_pkg::IDX_TOP;
					end
				end
				ST_DIV: begin
					if (idx_q == '0) begin
						state_q <= ST_MERGE;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_MERGE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == mpn_pkg::OP_RENDER) begin
			for (int j = 0; j < mpn_pkg::NUM_LANES; j++) begin
				mask_q[j] <= mask_eff[j];
			end
		end
	end

	assign ctrl.load = in_acc && (s_tuser == mpn_pkg::OP_RENDER);
	assign ctrl.step = (state_q == ST_DIV);
	assign ctrl.idx  = idx_q;

	// ---- three divider lanes ----
	for (genvar j = 0; j < mpn_pkg::NUM_LANES; j++) begin : g_lane
		mpn_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (sample[j]),
			.divisor(divisor),
			.level  (level[j])
		);
	end

	mpn_merge u_merge (
		.color_mode(color_mode_q),
		.level_r   (level[0]),
		.level_g   (level[1]),
		.level_b   (level[2]),
		.mask_r    (mask_q[0]),
		.mask_g    (mask_q[1]),
		.mask_b    (mask_q[2]),
		.pixel     (pixel)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= pixel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

[src/mpn_lane.sv]
// One channel divider: restoring division of sample*255 by the divisor,
// one quotient bit per step, MSB first. Bit 8 set means saturate.
module mpn_lane #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mpn_pkg::lane_ctrl_t          ctrl,
	input  logic [SAMPLE_BITS-1:0]       sample,
	input  logic [SAMPLE_BITS-1:0]       divisor,
	output logic [mpn_pkg::LEVEL_W-1:0]  level
);

	localparam int REM_W = SAMPLE_BITS + 8;

	logic [REM_W-1:0]           rem_q;
	logic [SAMPLE_BITS-1:0]     div_q;
	logic [mpn_pkg::QUOT_W-1:0] quot_q;
	logic [REM_W-1:0]           trial;

	assign trial = {8'b0, div_q} << ctrl.idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
		end else if (ctrl.load) begin
			quot_q <= '0;
		end else if (ctrl.step && rem_q >= trial) begin
			quot_q[ctrl.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			// x*255 as (x << 8) - x
			rem_q <= {sample, 8'b0} - {8'b0, sample};
			div_q <= divisor;
		end else if (ctrl.step && rem_q >= trial) begin
			rem_q <= rem_q - trial;
		end
	end

	assign level = quot_q[mpn_pkg::QUOT_W-1] ? mpn_pkg::LEVEL_MAX
	                                         : quot_q[mpn_pkg::LEVEL_W-1:0];

endmodule

[src/mpn_merge.sv]
// Combines the three lane levels with the masks into one RGBA pixel; gray mode uses only the red level and mask.
module mpn_merge (
	input  logic                        color_mode,
	input  logic [mpn_pkg::LEVEL_W-1:0] level_r,
	input  logic [mpn_pkg::LEVEL_W-1:0] level_g,
	input  logic [mpn_pkg::LEVEL_W-1:0] level_b,
	input  logic [mpn_pkg::MASK_W-1:0]  mask_r,
	input  logic [mpn_pkg::MASK_W-1:0]  mask_g,
	input  logic [mpn_pkg::MASK_W-1:0]  mask_b,
	output mpn_pkg::pixel_t             pixel
);

	logic zr, zg, zb;

	assign zr = (mask_r == '0);
	assign zg = (mask_g == '0);
	assign zb = (mask_b == '0);

	always_comb begin
		if (!color_mode) begin
			pixel.red   = level_r;
			pixel.green = level_r;
			pixel.blue  = level_r;
			pixel.alpha = mask_r;
		end else if (zr && zg && zb) begin
			// fully masked: transparent, levels left as they are
			pixel.red   = level_r;
			pixel.green = level_g;
			pixel.blue  = level_b;
			pixel.alpha = '0;
		end else begin
			pixel.red   = zr ? '0 : level_r;
			pixel.green = zg ? '0 : level_g;
			pixel.blue  = zb ? '0 : level_b;
			pixel.alpha = mpn_pkg::LEVEL_MAX;
		end
	end

endmodule

[src/mpn_check.sv]
module mpn_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == mpn_pkg::OP_RENDER |=> !s_tready)
		else $error("render request did not occupy the dividers");

	a_short_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != mpn_pkg::OP_RENDER |=> s_tready)
		else $error("start or measure request stalled the input");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind masked_peak_normalize_rgb8 mpn_check u_mpn_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.pready  (pready)
);

[tb/tb_masked_peak_normalize_rgb8.sv]
`timescale 1ns / 1ps

// Self-checking bench for masked_peak_normalize_rgb8.
// Requests go in on the slave stream; a local predictor keeps its own running
// peak and register copies and queues one expected RGBA pixel per render
// request. The checker pops that queue on every accepted output pixel.
module tb_masked_peak_normalize_rgb8;

	localparam int          SAMPLE_BITS    = 16;
	localparam int          TDATA_W        = ((3*SAMPLE_BITS+24+7)/8)*8;
	localparam logic [1:0]  OP_START       = mpn_pkg::OP_START;
	localparam logic [1:0]  OP_MEASURE     = mpn_pkg::OP_MEASURE;
	localparam logic [1:0]  OP_RENDER      = mpn_pkg::OP_RENDER;
	localparam logic [1:0]  OP_UNUSED      = 2'd3;   // no such opcode; block must ignore it
	// long enough to clear anything still in flight after a render
	localparam int          SETTLE_CYCLES  = 16;
	localparam int          WATCHDOG_LIMIT = 2000;

	// request payload, laid out exactly as s_tdata (red sample in the low bits)
	typedef struct packed {
		logic [7:0]  blue_mask;
		logic [15:0] blue_sample;
		logic [7:0]  green_mask;
		logic [15:0] green_sample;
		logic [7:0]  red_mask;
		logic [15:0] red_sample;
	} planes_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// tdata, from bit 0: red_sample, red_mask, green_sample, green_mask,
	// blue_sample, blue_mask
	logic [TDATA_W-1:0] s_tdata  = '0;
	// tuser: opcode
	logic [1:0]         s_tuser  = OP_START;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// tdata, from bit 0: red_out, green_out, blue_out, alpha_out
	logic [31:0]        m_tdata;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [mpn_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state, mirrors the block after reset
	logic [15:0] peak_level = '0;
	logic        colour_on  = 1'b0;
	logic        mask_on    = 1'b0;
	mpn_pkg::pixel_t pixel_q[$];

	int          send_gap_pct   = 7;
	int          recv_stall_pct = 51;
	int          errors         = 0;
	int          idle_cycles    = 0;
	logic [1:0]  cfg_seq        = '0;

	masked_peak_normalize_rgb8 #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// sample * 255 / divisor, clipped to a full byte
	function automatic logic [7:0] scale_level(logic [15:0] sample, logic [15:0] divisor);
		int unsigned q;
		q = (32'(sample) * 32'd255) / 32'(divisor);
		return (q > 32'd255) ? mpn_pkg::LEVEL_MAX : q[7:0];
	endfunction

	function automatic mpn_pkg::pixel_t render_pixel(planes_t pl);
		logic [7:0]      rm, gm, bm;
		logic [15:0]     divisor;
		mpn_pkg::pixel_t px;
		// with masking off every mask reads as fully opaque
		rm = mask_on ? pl.red_mask   : mpn_pkg::MASK_FULL;
		gm = mask_on ? pl.green_mask : mpn_pkg::MASK_FULL;
		bm = mask_on ? pl.blue_mask  : mpn_pkg::MASK_FULL;
		// tiny peaks (zero included) fall back to a divisor of 255
		divisor = (peak_level < 16'(mpn_pkg::SMALL_PEAK))
		          ? 16'(mpn_pkg::DIV_DEFAULT) : peak_level;
		px.red = scale_level(pl.red_sample, divisor);
		if (!colour_on) begin
			// gray: one plane, its mask only drives alpha, level never zeroed
			px.green = px.red;
			px.blue  = px.red;
			px.alpha = rm;
		end else begin
			px.green = scale_level(pl.green_sample, divisor);
			px.blue  = scale_level(pl.blue_sample, divisor);
			if (rm == 8'h00 && gm == 8'h00 && bm == 8'h00) begin
				// fully transparent: channels keep their levels
				px.alpha = 8'h00;
			end else begin
				px.alpha = mpn_pkg::LEVEL_MAX;
				if (rm == 8'h00) px.red   = 8'h00;
				if (gm == 8'h00) px.green = 8'h00;
				if (bm == 8'h00) px.blue  = 8'h00;
			end
		end
		return px;
	endfunction

	// called once per accepted request
	task automatic track_request(input logic [1:0] op, input planes_t pl);
		logic [7:0] rm;
		rm = mask_on ? pl.red_mask : mpn_pkg::MASK_FULL;
		unique case (op)
			OP_START: begin
				peak_level = '0;
			end
			OP_MEASURE: begin
				if (rm != 8'h00 && pl.red_sample > peak_level) peak_level = pl.red_sample;
			end
			OP_RENDER: begin
				pixel_q.push_back(render_pixel(pl));
			end
			default: ;   // unused opcode: nothing happens
		endcase
	endtask

	// ---------------------------------------------------------------- drivers

	function automatic planes_t pack_planes(logic [15:0] rs, logic [7:0] rm, logic [15:0] gs,
			logic [7:0] gm, logic [15:0] bs, logic [7:0] bm);
		planes_t pl;
		pl.red_sample   = rs;
		pl.red_mask     = rm;
		pl.green_sample = gs;
		pl.green_mask   = gm;
		pl.blue_sample  = bs;
		pl.blue_mask    = bm;
		return pl;
	endfunction

	// tight keeps samples tiny so the small-peak divisor and low quotients get hit
	function automatic logic [15:0] rand_sample(bit tight);
		if (tight) return 16'($urandom_range(0, 12));
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hffff;
			2:       return 16'($urandom_range(0, 7));
			3:       return 16'($urandom_range(0, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_mask();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic planes_t rand_planes(bit tight);
		return pack_planes(rand_sample(tight), rand_mask(), rand_sample(tight), rand_mask(),
			rand_sample(tight), rand_mask());
	endfunction

	// one request on the slave stream; valid is left high on return so that
	// back-to-back requests stream without a bubble
	task automatic send_request(input logic [1:0] op, input planes_t pl);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= TDATA_W'(pl);
		do @(posedge clk); while (!s_tready);
		track_request(op, pl);
	endtask

	// stop sending and wait for every queued pixel; with settle, also let
	// any measure or start still in the pipe retire before a register write
	task automatic drain_pixels(input bit settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup then access; upper bits are junk the block must drop
	task automatic write_register(input logic reg_sel, input logic bit_value);
		logic [31:0] value;
		value = ($urandom & 32'hffff_fffe) | 32'(bit_value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == mpn_pkg::REG_COLOR_MODE) colour_on = value[0];
		else mask_on = value[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic colour, input logic masked);
		drain_pixels(1'b1);
		write_register(mpn_pkg::REG_COLOR_MODE, colour);
		write_register(mpn_pkg::REG_MASK_ENABLE, masked);
	endtask

	// ---------------------------------------------------------------- tests

	// peak still zero after reset, then a peak of 3: both divide by 255
	task automatic test_small_peak();
		send_request(OP_RENDER,  pack_planes(16'hffff, 8'hff, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_RENDER,  pack_planes(16'd200,  8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_START,   pack_planes(16'h0,    8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_MEASURE, pack_planes(16'd3,    8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_RENDER,  pack_planes(16'd1000, 8'h12, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_RENDER,  pack_planes(16'd3,    8'h34, 16'h0, 8'h0, 16'h0, 8'h0));
	endtask

	// opcode 3 with everything high must not touch the peak
	task automatic test_unused_opcode();
		send_request(OP_UNUSED, pack_planes(16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 8'hff));
		send_request(OP_RENDER, pack_planes(16'd3,    8'hff, 16'h0,    8'h0,  16'h0,    8'h0));
	endtask

	// full-scale peak; green and blue junk is ignored in gray
	task automatic test_gray_extremes();
		send_request(OP_START,   pack_planes(16'h0,    8'h00, 16'h0,    8'h00, 16'h0,    8'h00));
		send_request(OP_MEASURE, pack_planes(16'hffff, 8'h00, 16'h0,    8'h00, 16'h0,    8'h00));
		send_request(OP_RENDER,  pack_planes(16'hffff, 8'hff, 16'h1234, 8'h00, 16'h5678, 8'hff));
		send_request(OP_RENDER,  pack_planes(16'h8000, 8'h80, 16'hffff, 8'hff, 16'h0,    8'h00));
		send_request(OP_RENDER,  pack_planes(16'h0000, 8'h00, 16'hffff, 8'hff, 16'hffff, 8'hff));
	endtask

	// masked measure skipped; gray level survives a zero mask, alpha does not
	task automatic test_gray_masks();
		set_mode(1'b0, 1'b1);
		send_request(OP_START,   pack_planes(16'h0,    8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_MEASURE, pack_planes(16'd5000, 8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_MEASURE, pack_planes(16'd1000, 8'h01, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_RENDER,  pack_planes(16'd1000, 8'h00, 16'h0, 8'h0, 16'h0, 8'h0));
		send_request(OP_RENDER,  pack_planes(16'd500,  8'h5a, 16'h0, 8'h0, 16'h0, 8'h0));
	endtask

	// colour: all masks clear, one channel masked, samples at and above the peak
	task automatic test_color_masks();
		set_mode(1'b1, 1'b1);
		send_request(OP_RENDER, pack_planes(16'd400,  8'h00, 16'd800,  8'h00, 16'd999,  8'h00));
		send_request(OP_RENDER, pack_planes(16'd900,  8'h00, 16'd250,  8'h80, 16'd1,    8'hff));
		send_request(OP_RENDER, pack_planes(16'd2000, 8'h01, 16'hffff, 8'h02, 16'd1000, 8'h03));
	endtask

	// frames of measure then render with random content; some noise, some
	// frames without a start, mode changes between frames
	task automatic test_random_traffic(input int n_items, input int gap_pct, input int stall_pct);
		int         sent;
		int         n_meas;
		int         n_rend;
		bit         tight;
		logic [1:0] op;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		sent           = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 2) == 0) begin
				// walk all four mode pairs so both extremes come round
				set_mode(cfg_seq[0], cfg_seq[1]);
				cfg_seq = cfg_seq + 2'd1;
			end
			tight  = ($urandom_range(0, 3) == 0);
			n_meas = $urandom_range(1, 12);
			n_rend = $urandom_range(1, 12);
			// now and then skip the start so the old peak carries over
			if ($urandom_range(0, 7) != 0) begin
				send_request(OP_START, rand_planes(tight));
				sent++;
			end
			repeat (n_meas) begin
				op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_MEASURE;
				send_request(op, rand_planes(tight));
				if (op != OP_UNUSED) sent++;
			end
			// now and then the sender holds off until the pipe is empty
			if ($urandom_range(0, 4) == 0) drain_pixels(1'b0);
			repeat (n_rend) begin
				op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_RENDER;
				send_request(op, rand_planes(tight));
				if (op != OP_UNUSED) sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------- checker

	// receiver stalls at random; each accepted pixel is checked byte by byte
	always @(posedge clk) begin : pixel_check
		mpn_pkg::pixel_t want;
		string  lane_name [4];
		lane_name = '{"red_out", "green_out", "blue_out", "alpha_out"};
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				errors++;
				$display("%0t: pixel with nothing expected, expected none, got %h", $time, m_tdata);
			end else begin
				want = pixel_q.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (m_tdata[i*8 +: 8] !== want[i*8 +: 8]) begin
						errors++;
						$display("%0t: %s mismatch, expected %0d, got %0d", $time, lane_name[i],
							want[i*8 +: 8], m_tdata[i*8 +: 8]);
					end
				end
			end
		end
	end

	// nothing moving on any port for too long means a hang
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mode first: gray, masking off; the mask tests then set their own mode
		test_small_peak();
		test_unused_opcode();
		test_gray_extremes();
		test_gray_masks();
		test_color_masks();

		// idling: sender light / receiver heavy, then swapped, then none
		test_random_traffic(480, 7, 51);
		test_random_traffic(480, 51, 7);
		test_random_traffic(490, 0, 0);

		drain_pixels(1'b1);
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[masked_peak_normalize_rgb8.f]
src/mpn_pkg.sv
src/mpn_lane.sv
src/mpn_merge.sv
src/masked_peak_normalize_rgb8.sv
src/mpn_check.sv
tb/tb_masked_peak_normalize_rgb8.sv
